### src/asa_pkg.sv
// Shared constants for the atlas shelf allocator: field widths, reset values,
// register indexes and result status codes.
// No dependencies.
package asa_pkg;

	// field widths
	localparam int unsigned RECT_W  = 15;
	localparam int unsigned SIZE_W  = 16;
	localparam int unsigned PAD_W   = 4;
	localparam int unsigned COORD_W = 15;
	localparam int unsigned STAT_W  = 2;

	// atlas side after reset
	localparam logic [SIZE_W-1:0] INITIAL_SIZE = 16'd256;

	// configuration register indexes and reset values
	localparam logic REG_MAX_ATLAS = 1'b0;
	localparam logic REG_PAD       = 1'b1;
	localparam logic [SIZE_W-1:0] MAX_ATLAS_RST = 16'd4096;
	localparam logic [PAD_W-1:0]  PAD_RST       = 4'd1;

	// request operations
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// result status codes
	localparam logic [STAT_W-1:0] ST_PLACED  = 2'd0;
	localparam logic [STAT_W-1:0] ST_GROWN   = 2'd1;
	localparam logic [STAT_W-1:0] ST_NO_ROOM = 2'd2;
	localparam logic [STAT_W-1:0] ST_CLEARED = 2'd3;

endpackage

### src/atlas_shelf_allocator.sv
// Shelf packing allocator for a growing 2D atlas, top level.
// Depends on asa_pkg.
//
// Each request word on the slave stream is either an allocate (tuser 0) or a
// clear (tuser 1) and yields exactly one result word on the master stream.
// The block works on one request at a time under a small sequencer. A clear
// passes through the pad state to done. An allocate passes through the pad
// and wrap states, where an oversized padded side ends it, then the fit state,
// where it is placed without growth or enters the growth search, which makes
// one pass of the shared size test/double unit per step in the grow state.
// tready is high only while the sequencer is idle; the finished result sits
// in an output register so the next request can be taken while it waits. A
// "grown" result means the atlas was enlarged and the cursor reset: the caller
// replays its earlier blocks and retries the request.
module atlas_shelf_allocator (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration write port
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [asa_pkg::SIZE_W-1:0]   cfg_data,
	// request stream
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [31:0]                  s_axis_tdata,  // rect_width[14:0], rect_height[29:15]
	input  logic [0:0]                   s_axis_tuser,  // operation[0]
	// result stream
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [63:0]                  m_axis_tdata,  // block_x[14:0], block_y[29:15],
	                                                    // atlas_width[45:30], atlas_height[61:46]
	output logic [1:0]                   m_axis_tuser   // status[1:0]
);
	import asa_pkg::*;

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PAD  = 3'd1;
	localparam logic [2:0] S_WRAP = 3'd2;
	localparam logic [2:0] S_FIT  = 3'd3;
	localparam logic [2:0] S_GROW = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]         state_q;

	logic [SIZE_W-1:0]  max_atlas_q;
	logic [PAD_W-1:0]   pad_q;

	logic [SIZE_W-1:0]  cursor_x_q, cursor_y_q, shelf_h_q, cur_w_q, cur_h_q;

	logic               op_q;
	logic [RECT_W-1:0]  rw_q, rh_q;
	logic [SIZE_W-1:0]  pw_q, ph_q;
	logic [SIZE_W-1:0]  gw_q, gh_q;

	logic [STAT_W-1:0]  res_st_q;
	logic [COORD_W-1:0] res_bx_q, res_by_q;

	logic               out_valid_q;
	logic [63:0]        out_data_q;
	logic [1:0]         out_user_q;

	// sums used by the fit and growth tests
	logic [SIZE_W:0]    row_end, col_end, pw_ext;
	logic [SIZE_W+1:0]  shelf_end;
	logic [SIZE_W:0]    mx_ext, gw_ext, gh_ext;
	logic               fit_a, fit_b, at_max, grow_stuck;
	logic [SIZE_W:0]    dbl_w, dbl_h;
	logic [SIZE_W-1:0]  nxt_w, nxt_h;
	logic               out_load;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	assign pw_ext    = {1'b0, pw_q};
	assign mx_ext    = {1'b0, max_atlas_q};
	assign gw_ext    = {1'b0, gw_q};
	assign gh_ext    = {1'b0, gh_q};
	assign row_end   = {1'b0, cursor_x_q} + pw_ext;
	assign col_end   = {1'b0, cursor_y_q} + {1'b0, ph_q};
	assign shelf_end = {2'b00, cursor_y_q} + {2'b00, shelf_h_q} + {2'b00, ph_q};

	// shared growth unit: fit tests against the proposal, then one doubling step
	always_comb begin
		fit_a  = (pw_ext <= gw_ext) && (shelf_end <= {1'b0, gh_ext});
		fit_b  = (row_end <= gw_ext) && (col_end <= gh_ext);
		at_max = (gw_ext >= mx_ext) && (gh_ext >= mx_ext);
		dbl_w  = gw_ext;
		dbl_h  = gh_ext;
		if (gw_q == gh_q && gw_ext < mx_ext) begin
			dbl_w = {gw_q, 1'b0};
			dbl_h = {gh_q, 1'b0};
		end else if (gw_q < gh_q && gw_ext < mx_ext) begin
			dbl_w = {gw_q, 1'b0};
		end else if (gh_q < gw_q && gh_ext < mx_ext) begin
			dbl_h = {gh_q, 1'b0};
		end else if (gw_ext < mx_ext) begin
			dbl_w = {gw_q, 1'b0};
		end else if (gh_ext < mx_ext) begin
			dbl_h = {gh_q, 1'b0};
		end
		// clamp to the maximum
		nxt_w = (dbl_w > mx_ext) ? max_atlas_q : dbl_w[SIZE_W-1:0];
		nxt_h = (dbl_h > mx_ext) ? max_atlas_q : dbl_h[SIZE_W-1:0];
		grow_stuck = (nxt_w == gw_q) && (nxt_h == gh_q);
	end

	assign out_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_atlas_q <= MAX_ATLAS_RST;
			pad_q       <= PAD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_ATLAS: max_atlas_q <= cfg_data;
				REG_PAD:       pad_q       <= cfg_data[PAD_W-1:0];
				default:       ;
			endcase
		end
	end

	// sequencer and packing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cursor_x_q <= '0;
			cursor_y_q <= '0;
			shelf_h_q  <= '0;
			cur_w_q    <= INITIAL_SIZE;
			cur_h_q    <= INITIAL_SIZE;
			gw_q       <= INITIAL_SIZE;
			gh_q       <= INITIAL_SIZE;
			res_st_q   <= ST_NO_ROOM;
			res_bx_q   <= '0;
			res_by_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) state_q <= S_PAD;
				end
				S_PAD: begin
					res_bx_q <= '0;
					res_by_q <= '0;
					if (op_q == OP_CLEAR) begin
						cursor_x_q <= '0;
						cursor_y_q <= '0;
						shelf_h_q  <= '0;
						res_st_q   <= ST_CLEARED;
						state_q    <= S_DONE;
					end else begin
						state_q <= S_WRAP;
					end
				end
				S_WRAP: begin
					if (pw_q > max_atlas_q || ph_q > max_atlas_q) begin
						res_st_q <= ST_NO_ROOM;
						state_q  <= S_DONE;
					end else begin
						// start a new shelf when the row is full
						if (row_end > {1'b0, cur_w_q}) begin
							cursor_x_q <= '0;
							cursor_y_q <= cursor_y_q + shelf_h_q;
							shelf_h_q  <= '0;
						end
						state_q <= S_FIT;
					end
				end
				S_FIT: begin
					if (col_end > {1'b0, cur_h_q}) begin
						gw_q    <= cur_w_q;
						gh_q    <= cur_h_q;
						state_q <= S_GROW;
					end else begin
						res_bx_q   <= cursor_x_q[COORD_W-1:0];
						res_by_q   <= cursor_y_q[COORD_W-1:0];
						cursor_x_q <= row_end[SIZE_W-1:0];
						if (ph_q > shelf_h_q) shelf_h_q <= ph_q;
						res_st_q   <= ST_PLACED;
						state_q    <= S_DONE;
					end
				end
				S_GROW: begin
					if (fit_a || fit_b) begin
						cur_w_q    <= gw_q;
						cur_h_q    <= gh_q;
						cursor_x_q <= '0;
						cursor_y_q <= '0;
						shelf_h_q  <= '0;
						res_st_q   <= ST_GROWN;
						state_q    <= S_DONE;
					end else if (at_max || grow_stuck) begin
						res_st_q <= ST_NO_ROOM;
						state_q  <= S_DONE;
					end else begin
						gw_q <= nxt_w;
						gh_q <= nxt_h;
					end
				end
				S_DONE: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request capture and padded size
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_q <= s_axis_tuser[0];
			rw_q <= s_axis_tdata[RECT_W-1:0];
			rh_q <= s_axis_tdata[2*RECT_W-1:RECT_W];
		end
		if (state_q == S_PAD) begin
			pw_q <= {1'b0, rw_q} + {{(SIZE_W-PAD_W-1){1'b0}}, pad_q, 1'b0};
			ph_q <= {1'b0, rh_q} + {{(SIZE_W-PAD_W-1){1'b0}}, pad_q, 1'b0};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {2'b00, cur_h_q, cur_w_q, res_by_q, res_bx_q};
			out_user_q <= res_st_q;
		end
	end

endmodule

### sim/testbench.sv
// Self-checking testbench for the atlas shelf allocator: request words in, one
// result word out each, checked against an in-bench shelf packing predictor.
// Depends on asa_pkg and atlas_shelf_allocator.
module testbench;
	import asa_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 1000000;
	// longest request is one that runs the growth search
	localparam int unsigned DRAIN_CYCLES = 32;
	localparam int unsigned MAX_REPORTS  = 10;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [COORD_W-1:0] block_x;
		logic [COORD_W-1:0] block_y;
		logic [SIZE_W-1:0]  atlas_w;
		logic [SIZE_W-1:0]  atlas_h;
	} placement_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic              cfg_index = REG_MAX_ATLAS;
	logic [SIZE_W-1:0] cfg_data = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [31:0]       s_axis_tdata = '0;   // rect_width[14:0], rect_height[29:15]
	logic [0:0]        s_axis_tuser = '0;   // operation[0]
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [63:0]       m_axis_tdata;        // block_x[14:0], block_y[29:15],
	                                        // atlas_width[45:30], atlas_height[61:46]
	logic [1:0]        m_axis_tuser;        // status[1:0]

	atlas_shelf_allocator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// predictor state, 32-bit so the sums never wrap early
	int unsigned max_side, pad_px;
	int unsigned cur_x, cur_y, shelf_h, atlas_w, atlas_h;

	placement_t  pending_placements[$];
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;

	// stimulus controls
	bit          req_gaps = 1'b1;
	bit          sink_stalls = 1'b1;
	bit          req_up = 1'b0;
	int unsigned hold_cycles = 0;
	logic [STAT_W-1:0] last_status = ST_PLACED;
	int unsigned last_w, last_h;

	initial begin
		forever #2 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic void reset_predictor();
		max_side = MAX_ATLAS_RST;
		pad_px   = PAD_RST;
		cur_x    = 0;
		cur_y    = 0;
		shelf_h  = 0;
		atlas_w  = INITIAL_SIZE;
		atlas_h  = INITIAL_SIZE;
	endfunction

	// doubling search; nw/nh valid only when it returns 1
	function automatic bit find_grown_size(input int unsigned pw, input int unsigned ph,
			output int unsigned nw, output int unsigned nh);
		int unsigned w, h, w0, h0;
		bit fits, stuck;
		w = atlas_w;
		h = atlas_h;
		fits = 1'b0;
		stuck = 1'b0;
		while (!fits && !stuck) begin
			if ((pw <= w && cur_y + shelf_h + ph <= h) || (cur_x + pw <= w && cur_y + ph <= h)) begin
				fits = 1'b1;
			end else if (w >= max_side && h >= max_side) begin
				stuck = 1'b1;
			end else begin
				w0 = w;
				h0 = h;
				if (w == h && w < max_side) begin
					w *= 2;
					h *= 2;
				end else if (w < h && w < max_side) begin
					w *= 2;
				end else if (h < w && h < max_side) begin
					h *= 2;
				end else if (w < max_side) begin
					w *= 2;
				end else if (h < max_side) begin
					h *= 2;
				end else begin
					stuck = 1'b1;
				end
				if (!stuck) begin
					if (w > max_side) w = max_side;
					if (h > max_side) h = max_side;
					if (w == w0 && h == h0) stuck = 1'b1;
				end
			end
		end
		nw = w;
		nh = h;
		return fits;
	endfunction

	// expected result of one request; advances the predictor state
	function automatic placement_t place_request(input logic op, input int unsigned rw,
			input int unsigned rh);
		placement_t  res;
		int unsigned pw, ph, bx, by, nw, nh;
		bit          ok;
		res.status = ST_NO_ROOM;
		bx = 0;
		by = 0;
		if (op == OP_CLEAR) begin
			cur_x = 0;
			cur_y = 0;
			shelf_h = 0;
			res.status = ST_CLEARED;
		end else begin
			pw = (rw & 32'h7FFF) + 2 * pad_px;
			ph = (rh & 32'h7FFF) + 2 * pad_px;
			if (pw <= max_side && ph <= max_side) begin
				ok = 1'b1;
				// new shelf; kept even if the request later fails
				if (cur_x + pw > atlas_w) begin
					cur_x = 0;
					cur_y = (cur_y + shelf_h) & 32'hFFFF;
					shelf_h = 0;
				end
				if (cur_y + ph > atlas_h) begin
					ok = 1'b0;
					if (find_grown_size(pw, ph, nw, nh)) begin
						atlas_w = nw & 32'hFFFF;
						atlas_h = nh & 32'hFFFF;
						cur_x = 0;
						cur_y = 0;
						shelf_h = 0;
						res.status = ST_GROWN;
					end
				end
				if (ok) begin
					bx = cur_x;
					by = cur_y;
					cur_x = (cur_x + pw) & 32'hFFFF;
					if (ph > shelf_h) shelf_h = ph & 32'hFFFF;
					res.status = ST_PLACED;
				end
			end
		end
		res.block_x = bx[COORD_W-1:0];
		res.block_y = by[COORD_W-1:0];
		res.atlas_w = atlas_w[SIZE_W-1:0];
		res.atlas_h = atlas_h[SIZE_W-1:0];
		return res;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int unsigned idle_len();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) return 0;
		if (pick < 85) return $urandom_range(1, 3);
		if (pick < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// rectangle side, mostly small against the span, sometimes anything
	function automatic int unsigned rand_side(input int unsigned span);
		int unsigned top, pick;
		top = (span > 32767) ? 32767 : span;
		pick = $urandom_range(0, 99);
		if (pick < 60) return $urandom_range(0, top / 8);
		if (pick < 90) return $urandom_range(0, top / 2);
		return $urandom_range(0, 32767);
	endfunction

	// result side: random stalls, plus a long hold-off when a test asks for one
	int unsigned sink_wait = 0;
	always @(posedge clk) begin
		if (hold_cycles != 0) begin
			sink_wait = hold_cycles;
			hold_cycles = 0;
		end else if (sink_wait == 0 && sink_stalls && $urandom_range(0, 3) == 0) begin
			sink_wait = idle_len();
		end
		if (sink_wait != 0) begin
			m_axis_tready <= 1'b0;
			sink_wait--;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		placement_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status  = m_axis_tuser;
			got.block_x = m_axis_tdata[14:0];
			got.block_y = m_axis_tdata[29:15];
			got.atlas_w = m_axis_tdata[45:30];
			got.atlas_h = m_axis_tdata[61:46];
			if (pending_placements.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("unexpected result word: status %0d x %0d y %0d size %0dx%0d",
						got.status, got.block_x, got.block_y, got.atlas_w, got.atlas_h);
				mismatches++;
			end else begin
				want = pending_placements.pop_front();
				if (got.status != want.status || got.block_x != want.block_x ||
						got.block_y != want.block_y || got.atlas_w != want.atlas_w ||
						got.atlas_h != want.atlas_h) begin
					if (mismatches < MAX_REPORTS) begin
						$display("mismatch at cycle %0d: exp status %0d x %0d y %0d size %0dx%0d",
							cycle_count, want.status, want.block_x, want.block_y,
							want.atlas_w, want.atlas_h);
						$display("    got status %0d x %0d y %0d size %0dx%0d",
							got.status, got.block_x, got.block_y,
							got.atlas_w, got.atlas_h);
					end
					mismatches++;
				end
			end
		end
	end

	// offer one request word, wait for acceptance, then maybe leave a gap
	task automatic send_request(input logic op, input int unsigned rw, input int unsigned rh);
		placement_t  want;
		int unsigned gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, rh[14:0], rw[14:0]};
		s_axis_tuser  <= op;
		req_up = 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		want = place_request(op, rw, rh);
		pending_placements.push_back(want);
		last_status = want.status;
		last_w = rw;
		last_h = rh;
		gap = req_gaps ? idle_len() : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			req_up = 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic stop_requests();
		if (req_up) begin
			s_axis_tvalid <= 1'b0;
			req_up = 1'b0;
		end
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (pending_placements.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// both registers, only with the block idle
	task automatic set_config(input int unsigned max_sz, input int unsigned pad);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_index <= REG_MAX_ATLAS;
		cfg_data  <= max_sz[SIZE_W-1:0];
		@(posedge clk);
		max_side = max_sz & 32'hFFFF;
		cfg_index <= REG_PAD;
		cfg_data  <= {{(SIZE_W-PAD_W){1'b0}}, pad[PAD_W-1:0]};
		@(posedge clk);
		pad_px = pad & 32'hF;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// random allocations and occasional clears; a grown result is usually followed by the retry
	task automatic run_random(input int unsigned count, input int unsigned span);
		int unsigned i;
		for (i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				req_gaps    = ($urandom_range(0, 3) != 0);
				sink_stalls = ($urandom_range(0, 3) != 0);
			end
			if (last_status == ST_GROWN && $urandom_range(0, 9) < 7)
				send_request(OP_ALLOC, last_w, last_h);
			else if ($urandom_range(0, 24) == 0)
				send_request(OP_CLEAR, $urandom_range(0, 32767), $urandom_range(0, 32767));
			else
				send_request(OP_ALLOC, rand_side(span), rand_side(span));
		end
		stop_requests();
	endtask

	// reset configuration: zero size, oversize, wrap, growth, clear, bit patterns
	task automatic test_directed();
		send_request(OP_ALLOC, 0, 0);
		send_request(OP_ALLOC, 10, 20);
		send_request(OP_ALLOC, 32767, 32767);
		send_request(OP_CLEAR, 15'h5555, 15'h2AAA);
		send_request(OP_ALLOC, 4094, 1);
		send_request(OP_ALLOC, 250, 5);
		send_request(OP_ALLOC, 100, 100);
		send_request(OP_ALLOC, 300, 300);
		send_request(OP_ALLOC, 300, 300);
		send_request(OP_ALLOC, 3000, 3000);
		send_request(OP_ALLOC, 3000, 3000);
		send_request(OP_ALLOC, 3000, 100);
		send_request(OP_ALLOC, 4095, 4095);
		send_request(OP_ALLOC, 4094, 4094);
		send_request(OP_CLEAR, 15'h2AAA, 15'h5555);
		send_request(OP_ALLOC, 4094, 4094);
		send_request(OP_ALLOC, 15'h2AAA, 15'h5555);
		send_request(OP_ALLOC, 1, 1);
		send_request(OP_ALLOC, 2000, 3000);
		send_request(OP_CLEAR, 0, 0);
		stop_requests();
	endtask

	// growth capped at a modest maximum: many requests end in no room
	task automatic test_growth_capped();
		set_config(1024, 0);
		run_random(110, 1024);
	endtask

	task automatic test_default_random();
		set_config(4096, 1);
		run_random(140, 4096);
	endtask

	// maximum below the present atlas size: growth never helps
	task automatic test_max_below_size();
		set_config(300, 15);
		run_random(50, 300);
	endtask

	// register extremes and coordinates past 15 bits
	task automatic test_register_extremes();
		set_config(1, 15);
		send_request(OP_ALLOC, 0, 0);
		send_request(OP_ALLOC, 5, 5);
		stop_requests();
		set_config(0, 0);
		send_request(OP_ALLOC, 0, 0);
		send_request(OP_ALLOC, 1, 0);
		send_request(OP_ALLOC, 0, 1);
		stop_requests();
		set_config(32768, 0);
		send_request(OP_CLEAR, 0, 0);
		send_request(OP_ALLOC, 32767, 32767);
		send_request(OP_ALLOC, 32767, 32767);
		send_request(OP_ALLOC, 32767, 1);
		send_request(OP_ALLOC, 1, 1);
		send_request(OP_ALLOC, 0, 0);
		send_request(OP_ALLOC, 0, 0);
		stop_requests();
	endtask

	task automatic test_large_atlas();
		set_config(32768, 15);
		send_request(OP_CLEAR, 0, 0);
		run_random(130, 32768);
	endtask

	// long receiver hold-off with the sender pushing: input must stall
	task automatic test_backpressure();
		int unsigned i;
		set_config(20000, 7);
		sink_stalls = 1'b0;
		req_gaps = 1'b0;
		hold_cycles = 300;
		for (i = 0; i < 40; i++)
			send_request(OP_ALLOC, $urandom_range(0, 2000), $urandom_range(0, 2000));
		stop_requests();
		sink_stalls = 1'b1;
	endtask

	initial begin
		reset_predictor();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_growth_capped();
		test_default_random();
		test_max_below_size();
		test_register_extremes();
		test_large_atlas();
		test_backpressure();
		wait_drained();
		if (mismatches == 0 && pending_placements.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### files.f
src/asa_pkg.sv
src/atlas_shelf_allocator.sv
sim/testbench.sv
